@@ src/fsp_pkg.sv @@
// Shared types and constants for the fixed-slot free-list pool.
// Used by every module of the block except fsp_ram; depends on nothing.
package fsp_pkg;

    // Fixed field widths of the ports
    localparam int unsigned OP_W       = 2;
    localparam int unsigned OFF_W      = 22;
    localparam int unsigned STAT_W     = 2;
    localparam int unsigned IDX_W      = 10;
    localparam int unsigned CNT_W      = 11;
    localparam int unsigned SLOTS_W    = 11;
    localparam int unsigned STRIDE_W   = 13;
    localparam int unsigned CFG_IDX_W  = 1;
    localparam int unsigned CFG_DATA_W = 13;

    // Register reset values and stride floor
    localparam logic [SLOTS_W-1:0]  POOL_SLOTS_RST  = 11'd1024;
    localparam logic [STRIDE_W-1:0] SLOT_STRIDE_RST = 13'd8;
    localparam int unsigned         STRIDE_MIN      = 4;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_POOL_SLOTS  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_SLOT_STRIDE = 1'b1;

    // Operation codes; code 3 does nothing
    localparam logic [OP_W-1:0] OP_TAKE    = 2'd0;
    localparam logic [OP_W-1:0] OP_RELEASE = 2'd1;
    localparam logic [OP_W-1:0] OP_REINIT  = 2'd2;

    // Result status codes
    localparam logic [STAT_W-1:0] ST_OK     = 2'd0;
    localparam logic [STAT_W-1:0] ST_EMPTY  = 2'd1;
    localparam logic [STAT_W-1:0] ST_REJECT = 2'd2;

    // Command queue between front and back
    localparam int unsigned Q_DEPTH = 2;

    // Classified command: op code plus the release quotient
    typedef struct packed {
        logic [OP_W-1:0]  op;
        logic [OFF_W-1:0] quo;
    } t_cmd;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_flags;

endpackage

@@ src/fsp_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module fsp_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

@@ src/fsp_front.sv @@
// Front end of the pool: accepts commands and divides release offsets by the stride.
// Depends on fsp_pkg; feeds fsp_queue.
module fsp_front #(
    parameter int unsigned MAX_STRIDE = 4096
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_start,
    input  logic                               i_hold,
    input  logic [fsp_pkg::OP_W-1:0]           i_operation,
    input  logic [fsp_pkg::OFF_W-1:0]          i_byte_offset,
    input  logic [$clog2(MAX_STRIDE+1)-1:0]    i_stride,
    input  fsp_pkg::t_q_flags                  i_qflags,
    output logic                               o_busy,
    output logic                               o_push,
    output fsp_pkg::t_cmd                      o_cmd
);

    localparam int unsigned DW   = $clog2(MAX_STRIDE + 1);
    localparam int unsigned CNTW = $clog2(fsp_pkg::OFF_W);

    typedef enum logic [2:0] {
        FE_IDLE = 3'b001,
        FE_DIV  = 3'b010,
        FE_PUSH = 3'b100
    } t_fe_state;

    t_fe_state                 r_state, n_state;
    logic [DW-1:0]             r_rem, n_rem;
    logic [fsp_pkg::OFF_W-1:0] r_quo, n_quo;
    logic [CNTW-1:0]           r_cnt, n_cnt;

    logic          w_accept;
    logic [DW:0]   w_trial;
    logic          w_ge;

    assign o_busy   = (r_state != FE_IDLE) || i_qflags.full || i_hold;
    assign w_accept = i_start && !o_busy;

    // One restoring-division step per cycle
    assign w_trial = {r_rem, r_quo[fsp_pkg::OFF_W-1]};
    assign w_ge    = (w_trial >= {1'b0, i_stride});

    always_comb begin
        n_state = r_state;
        n_rem   = r_rem;
        n_quo   = r_quo;
        n_cnt   = r_cnt;
        o_push  = 1'b0;
        o_cmd   = '{op: i_operation, quo: i_byte_offset};
        unique case (r_state)
            FE_IDLE: begin
                if (w_accept) begin
                    if (i_operation == fsp_pkg::OP_RELEASE) begin
                        n_rem   = '0;
                        n_quo   = i_byte_offset;
                        n_cnt   = CNTW'(fsp_pkg::OFF_W - 1);
                        n_state = FE_DIV;
                    end else begin
                        o_push = 1'b1;
                    end
                end
            end
            FE_DIV: begin
                n_rem = w_ge ? DW'(w_trial - {1'b0, i_stride}) : DW'(w_trial);
                n_quo = {r_quo[fsp_pkg::OFF_W-2:0], w_ge};
                n_cnt = r_cnt - 1'b1;
                if (r_cnt == '0) begin
                    n_state = FE_PUSH;
                end
            end
            FE_PUSH: begin
                o_cmd = '{op: fsp_pkg::OP_RELEASE, quo: r_quo};
                if (!i_qflags.full) begin
                    o_push  = 1'b1;
                    n_state = FE_IDLE;
                end
            end
            default: n_state = FE_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= FE_IDLE;
        end else begin
            r_state <= n_state;
        end
        r_rem <= n_rem;
        r_quo <= n_quo;
        r_cnt <= n_cnt;
    end

endmodule

@@ src/fsp_queue.sv @@
// Short command FIFO between the front and back ends of the pool.
// Depends on fsp_pkg.
module fsp_queue (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  fsp_pkg::t_cmd     i_cmd,
    input  logic              i_pop,
    output fsp_pkg::t_cmd     o_cmd,
    output fsp_pkg::t_q_flags o_flags
);

    localparam int unsigned AW = $clog2(fsp_pkg::Q_DEPTH);
    localparam int unsigned CW = $clog2(fsp_pkg::Q_DEPTH + 1);

    fsp_pkg::t_cmd r_mem [fsp_pkg::Q_DEPTH];
    logic [AW-1:0] r_wp, r_rp;
    logic [CW-1:0] r_cnt;

    assign o_cmd         = r_mem[r_rp];
    assign o_flags.full  = (r_cnt == CW'(fsp_pkg::Q_DEPTH));
    assign o_flags.empty = (r_cnt == '0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wp <= (r_wp == AW'(fsp_pkg::Q_DEPTH - 1)) ? '0 : r_wp + 1'b1;
            end
            if (i_pop) begin
                r_rp <= (r_rp == AW'(fsp_pkg::Q_DEPTH - 1)) ? '0 : r_rp + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (i_pop && !i_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
        if (i_push) begin
            r_mem[r_wp] <= i_cmd;
        end
    end

endmodule

@@ src/fsp_back.sv @@
// Back end of the pool: owns the link store, head and counts, executes commands.
// Depends on fsp_pkg and fsp_ram.
module fsp_back #(
    parameter int unsigned MAX_SLOTS  = 1024,
    parameter int unsigned MAX_STRIDE = 4096
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic [$clog2(MAX_SLOTS+1)-1:0]       i_eff_slots,
    input  logic [$clog2(MAX_STRIDE+1)-1:0]      i_stride,
    input  fsp_pkg::t_cmd                        i_cmd,
    input  fsp_pkg::t_q_flags                    i_qflags,
    output logic                                 o_pop,
    output logic                                 o_init,
    output logic                                 o_done,
    output logic [fsp_pkg::STAT_W-1:0]           o_status,
    output logic [fsp_pkg::IDX_W-1:0]            o_slot_index,
    output logic [fsp_pkg::OFF_W-1:0]            o_slot_offset,
    output logic [fsp_pkg::CNT_W-1:0]            o_free_slots,
    output logic [fsp_pkg::CNT_W-1:0]            o_used_slots
);

    localparam int unsigned IW = $clog2(MAX_SLOTS);
    localparam int unsigned CW = $clog2(MAX_SLOTS + 1);
    localparam int unsigned DW = $clog2(MAX_STRIDE + 1);
    localparam int unsigned PW = CW + DW;
    localparam int unsigned RstFree =
        (MAX_SLOTS < 1024) ? MAX_SLOTS : 1024;
    localparam logic [IW-1:0] LastAddr = IW'(MAX_SLOTS - 1);

    typedef enum logic [2:0] {
        BE_SWEEP = 3'b001,
        BE_IDLE  = 3'b010,
        BE_TAKE  = 3'b100
    } t_be_state;

    t_be_state                   r_state, n_state;
    logic [IW-1:0]               r_addr, n_addr;
    logic                        r_emit, n_emit;
    logic                        r_boot, n_boot;
    logic [CW-1:0]               r_head, n_head;
    logic [CW-1:0]               r_free, n_free;
    logic [CW-1:0]               r_used, n_used;
    logic [CW-1:0]               r_tidx, n_tidx;
    logic                        r_done, n_done;
    logic [fsp_pkg::STAT_W-1:0]  r_status, n_status;
    logic [fsp_pkg::IDX_W-1:0]   r_idx, n_idx;
    logic [fsp_pkg::OFF_W-1:0]   r_soff, n_soff;

    logic          w_we;
    logic [IW-1:0] w_waddr;
    logic [CW-1:0] w_wdata;
    logic [CW-1:0] w_rdata;
    logic [PW-1:0] w_prod;

    fsp_ram #(
        .WIDTH (CW),
        .DEPTH (MAX_SLOTS)
    ) u_link (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_raddr (r_head[IW-1:0]),
        .o_rdata (w_rdata)
    );

    assign w_prod = PW'(r_tidx) * PW'(i_stride);

    always_comb begin
        n_state  = r_state;
        n_addr   = r_addr;
        n_emit   = r_emit;
        n_boot   = r_boot;
        n_head   = r_head;
        n_free   = r_free;
        n_used   = r_used;
        n_tidx   = r_tidx;
        n_done   = 1'b0;
        n_status = r_status;
        n_idx    = r_idx;
        n_soff   = r_soff;
        o_pop    = 1'b0;
        w_we     = 1'b0;
        w_waddr  = r_addr;
        w_wdata  = CW'(r_addr) + CW'(1);
        unique case (r_state)
            BE_SWEEP: begin
                w_we = 1'b1;
                if (r_addr == LastAddr) begin
                    n_addr  = '0;
                    n_emit  = 1'b0;
                    n_boot  = 1'b0;
                    n_state = BE_IDLE;
                    if (r_emit) begin
                        n_head   = '0;
                        n_free   = i_eff_slots;
                        n_used   = '0;
                        n_done   = 1'b1;
                        n_status = fsp_pkg::ST_OK;
                        n_idx    = '0;
                        n_soff   = '0;
                    end
                end else begin
                    n_addr = r_addr + 1'b1;
                end
            end
            BE_IDLE: begin
                if (!i_qflags.empty) begin
                    o_pop = 1'b1;
                    case (i_cmd.op)
                        fsp_pkg::OP_TAKE: begin
                            if (r_free == '0 || r_head >= i_eff_slots) begin
                                n_done   = 1'b1;
                                n_status = fsp_pkg::ST_EMPTY;
                                n_idx    = '0;
                                n_soff   = '0;
                            end else begin
                                n_tidx  = r_head;
                                n_state = BE_TAKE;
                            end
                        end
                        fsp_pkg::OP_RELEASE: begin
                            n_done = 1'b1;
                            n_idx  = i_cmd.quo[fsp_pkg::IDX_W-1:0];
                            n_soff = '0;
                            if (r_used == '0 ||
                                32'(i_cmd.quo) >= 32'(i_eff_slots)) begin
                                n_status = fsp_pkg::ST_REJECT;
                            end else begin
                                n_status = fsp_pkg::ST_OK;
                                w_we     = 1'b1;
                                w_waddr  = i_cmd.quo[IW-1:0];
                                w_wdata  = r_head;
                                n_head   = CW'(i_cmd.quo);
                                n_free   = r_free + 1'b1;
                                n_used   = r_used - 1'b1;
                            end
                        end
                        fsp_pkg::OP_REINIT: begin
                            n_addr  = '0;
                            n_emit  = 1'b1;
                            n_state = BE_SWEEP;
                        end
                        default: begin
                            n_done   = 1'b1;
                            n_status = fsp_pkg::ST_OK;
                            n_idx    = '0;
                            n_soff   = '0;
                        end
                    endcase
                end
            end
            BE_TAKE: begin
                n_head   = w_rdata;
                n_free   = r_free - 1'b1;
                n_used   = r_used + 1'b1;
                n_done   = 1'b1;
                n_status = fsp_pkg::ST_OK;
                n_idx    = fsp_pkg::IDX_W'(r_tidx);
                n_soff   = fsp_pkg::OFF_W'(w_prod);
                n_state  = BE_IDLE;
            end
            default: n_state = BE_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= BE_SWEEP;
            r_addr  <= '0;
            r_emit  <= 1'b0;
            r_boot  <= 1'b1;
            r_head  <= '0;
            r_free  <= CW'(RstFree);
            r_used  <= '0;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_addr  <= n_addr;
            r_emit  <= n_emit;
            r_boot  <= n_boot;
            r_head  <= n_head;
            r_free  <= n_free;
            r_used  <= n_used;
            r_done  <= n_done;
        end
        r_tidx   <= n_tidx;
        r_status <= n_status;
        r_idx    <= n_idx;
        r_soff   <= n_soff;
    end

    assign o_init        = r_boot;
    assign o_done        = r_done;
    assign o_status      = r_status;
    assign o_slot_index  = r_idx;
    assign o_slot_offset = r_soff;
    assign o_free_slots  = fsp_pkg::CNT_W'(r_free);
    assign o_used_slots  = fsp_pkg::CNT_W'(r_used);

endmodule

@@ src/fixed_slot_free_list_pool.sv @@
// Top level of the fixed-slot free-list pool: configuration registers and wiring.
// Depends on fsp_pkg, fsp_front, fsp_queue and fsp_back.
//
//  Channel   Handshake               Fields
//  -------   ---------------------   ------------------------------------------------
//  command   i_start && !o_busy      i_operation, i_byte_offset
//  result    o_done (one cycle)      o_status, o_slot_index, o_slot_offset,
//                                    o_free_slots, o_used_slots
//  config    i_cfg_we                i_cfg_idx, i_cfg_data
//
//  A release raises o_done only after the front end's restoring divider has retired
//  one quotient bit of the 22-bit offset per cycle, and the front end takes no new
//  command until it has pushed the quotient. A take raises o_done after one link
//  store read, then the index-times-stride product; reinit after it rewrites every link.
//  After reset the block sweeps the link store with o_busy high; config writes still
//  land. Results cannot be stalled; a two-entry command queue lets the front end
//  take the next command while the back end is working.
module fixed_slot_free_list_pool #(
    parameter int unsigned MAX_SLOTS  = 1024,
    parameter int unsigned MAX_STRIDE = 4096
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    // command channel
    input  logic                             i_start,
    output logic                             o_busy,
    input  logic [fsp_pkg::OP_W-1:0]         i_operation,
    input  logic [fsp_pkg::OFF_W-1:0]        i_byte_offset,
    // result channel
    output logic                             o_done,
    output logic [fsp_pkg::STAT_W-1:0]       o_status,
    output logic [fsp_pkg::IDX_W-1:0]        o_slot_index,
    output logic [fsp_pkg::OFF_W-1:0]        o_slot_offset,
    output logic [fsp_pkg::CNT_W-1:0]        o_free_slots,
    output logic [fsp_pkg::CNT_W-1:0]        o_used_slots,
    // configuration port
    input  logic                             i_cfg_we,
    input  logic [fsp_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [fsp_pkg::CFG_DATA_W-1:0]   i_cfg_data
);

    localparam int unsigned CW = $clog2(MAX_SLOTS + 1);
    localparam int unsigned DW = $clog2(MAX_STRIDE + 1);

    logic [fsp_pkg::SLOTS_W-1:0]  r_pool_slots;
    logic [fsp_pkg::STRIDE_W-1:0] r_slot_stride;

    logic [CW-1:0]     w_eff_slots;
    logic [DW-1:0]     w_eff_stride;
    logic              w_front_busy;
    logic              w_init;
    logic              w_push;
    logic              w_pop;
    fsp_pkg::t_cmd     w_push_cmd;
    fsp_pkg::t_cmd     w_head_cmd;
    fsp_pkg::t_q_flags w_qflags;

    // Config writes land at once; the slot count bounds takes and releases at once, sets the free count at reinit
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pool_slots  <= fsp_pkg::POOL_SLOTS_RST;
            r_slot_stride <= fsp_pkg::SLOT_STRIDE_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                fsp_pkg::CFG_POOL_SLOTS:  r_pool_slots  <= i_cfg_data[fsp_pkg::SLOTS_W-1:0];
                fsp_pkg::CFG_SLOT_STRIDE: r_slot_stride <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Clamp slot count to [1, MAX_SLOTS]
    always_comb begin
        if (r_pool_slots == '0) begin
            w_eff_slots = CW'(1);
        end else if (32'(r_pool_slots) > MAX_SLOTS) begin
            w_eff_slots = CW'(MAX_SLOTS);
        end else begin
            w_eff_slots = CW'(r_pool_slots);
        end
    end

    // Clamp stride to [4, MAX_STRIDE]
    always_comb begin
        if (32'(r_slot_stride) < fsp_pkg::STRIDE_MIN) begin
            w_eff_stride = DW'(fsp_pkg::STRIDE_MIN);
        end else if (32'(r_slot_stride) > MAX_STRIDE) begin
            w_eff_stride = DW'(MAX_STRIDE);
        end else begin
            w_eff_stride = DW'(r_slot_stride);
        end
    end

    // Hold off commands while the post-reset sweep runs, the front end is dividing or pushing, or the queue is full
    assign o_busy = w_front_busy;

    fsp_front #(
        .MAX_STRIDE (MAX_STRIDE)
    ) u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_start       (i_start),
        .i_hold        (w_init),
        .i_operation   (i_operation),
        .i_byte_offset (i_byte_offset),
        .i_stride      (w_eff_stride),
        .i_qflags      (w_qflags),
        .o_busy        (w_front_busy),
        .o_push        (w_push),
        .o_cmd         (w_push_cmd)
    );

    fsp_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_cmd   (w_push_cmd),
        .i_pop   (w_pop),
        .o_cmd   (w_head_cmd),
        .o_flags (w_qflags)
    );

    fsp_back #(
        .MAX_SLOTS  (MAX_SLOTS),
        .MAX_STRIDE (MAX_STRIDE)
    ) u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_eff_slots   (w_eff_slots),
        .i_stride      (w_eff_stride),
        .i_cmd         (w_head_cmd),
        .i_qflags      (w_qflags),
        .o_pop         (w_pop),
        .o_init        (w_init),
        .o_done        (o_done),
        .o_status      (o_status),
        .o_slot_index  (o_slot_index),
        .o_slot_offset (o_slot_offset),
        .o_free_slots  (o_free_slots),
        .o_used_slots  (o_used_slots)
    );

endmodule

@@ src/fsp_checker.sv @@
// Port-level checks for the fixed-slot free-list pool, bound to the top level.
// Depends on fsp_pkg and fixed_slot_free_list_pool.
module fsp_checker #(
    parameter int unsigned MAX_SLOTS = 1024
) (
    input logic                             i_clk,
    input logic                             i_rst_n,
    input logic                             o_busy,
    input logic                             o_done,
    input logic [fsp_pkg::STAT_W-1:0]       o_status,
    input logic [fsp_pkg::IDX_W-1:0]        o_slot_index,
    input logic [fsp_pkg::OFF_W-1:0]        o_slot_offset,
    input logic [fsp_pkg::CNT_W-1:0]        o_free_slots,
    input logic [fsp_pkg::CNT_W-1:0]        o_used_slots
);

    // Status is a defined code whenever o_done is high
    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> (o_status == fsp_pkg::ST_OK || o_status == fsp_pkg::ST_EMPTY ||
                    o_status == fsp_pkg::ST_REJECT))
        else $error("undefined status code");

    // An empty take reports no slot
    a_empty_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_status == fsp_pkg::ST_EMPTY) |->
            (o_slot_index == '0 && o_slot_offset == '0))
        else $error("empty take reports a slot");

    // At each result, free plus used never exceeds MAX_SLOTS
    a_count_sum: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> (32'(o_free_slots) + 32'(o_used_slots) <= MAX_SLOTS))
        else $error("free plus used exceeds capacity");

    // Busy right out of reset while the link store is swept
    a_busy_after_reset: assert property (@(posedge i_clk)
        $rose(i_rst_n) |-> o_busy)
        else $error("commands taken during link sweep");

    // No result in the cycle after reset
    a_quiet_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_done)
        else $error("result right after reset");

endmodule

bind fixed_slot_free_list_pool fsp_checker #(.MAX_SLOTS(MAX_SLOTS)) u_fsp_checker (.*);
